FILE: rtl/gcpr_pkg.sv
// Shared constants and types for the grain rotate and close pair remover.
// Depends on nothing; imported by the top level.
package gcpr_pkg;

  // Store geometry
  localparam int MAX_ATOMS = 4096;
  localparam int ADDR_W    = $clog2(MAX_ATOMS);
  localparam int CNT_W     = ADDR_W + 1;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 27;
  localparam int OPOS_W    = 29;
  localparam int CFG_W     = 52;
  localparam int CIDX_W    = 3;

  // Stored word: {mark, kind, z, y, x}
  localparam int RAM_W     = 1 + 4 + POS_W + 2 * OPOS_W;

  // Remainder steps: one per bit of a coordinate difference magnitude
  localparam int DIV_STEPS = OPOS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECIDE = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BOX_X  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BOX_Y  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BOX_Z  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GRAIN  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_COS    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_SIN    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_CUTOFF = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_TLIM   = 3'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TYPE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_FIN,
    S_DC_GETI,
    S_DC_RDJ,
    S_DC_GETJ,
    S_DC_DIV,
    S_DC_SQ,
    S_DC_CMP,
    S_DC_FIN,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/gcpr_ram.sv
// Generic single-port RAM with registered read data (read before write).
// No dependencies.
module gcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/grain_rotate_close_pair_remover_top.sv
// Top level of the grain rotate and close pair remover: control, datapath, store.
// Depends on gcpr_pkg and gcpr_ram.
//
// Channel | Dir | Handshake             | Payload
// in      | in  | in_tvalid/in_tready   | in_tuser: mode; in_tdata: kind, x, y, z
// out     | out | out_tvalid/out_tready | out_tuser: status; out_tdata: result
// cfg     | in  | cfg_we                | cfg_index, cfg_wdata
//
// A load forms its products, then commits its rotation with the result; a rejected
// load or an empty decide goes straight to emit. A decide scans the stored atoms;
// each unmarked one passes the remainder, square and compare states: the remainder unit runs
// one bit a cycle over 29 bits, and the store port serves one read a cycle.
// Reset (rst_n low, synchronous) clears counters and sets configuration to defaults; marks of
// unloaded entries are never read, so the store needs no clearing pass.
// A finished result waits in the output register; the next item is taken.
module grain_rotate_close_pair_remover_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_tuser,   // [0] mode
  input  logic [87:0]                   in_tdata,   // kind[3:0], x[30:4], y[57:31], z[84:58]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [1:0]                    out_tuser,  // [1:0] status
  output logic [119:0]                  out_tdata,  // index[11:0], kind[15:12], x[44:16],
                                                    // y[73:45], z[100:74], removed[101],
                                                    // kept_count[114:102]
  input  logic                          cfg_we,
  input  logic [gcpr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [gcpr_pkg::CFG_W-1:0]    cfg_wdata
);
  import gcpr_pkg::*;

  localparam logic signed [47:0] OUT_LO = -48'sd134217728;
  localparam logic signed [47:0] OUT_HI = 48'sd268435455;
  localparam logic signed [47:0] RND    = 48'sd1 <<< (FRAC_BITS - 1);

  // Configuration registers
  logic [POS_W-1:0]  box_x_r, box_y_r, box_z_r;
  logic [51:0]       grain_r;
  logic signed [17:0] cos_r, sin_r;
  logic [31:0]       cutoff_r;
  logic [3:0]        tlim_r;

  // Counters and control
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, dptr_r, kept_r, j_r;
  logic              mode_r;
  status_t           status_r;

  // Load datapath
  logic [3:0]         kind_r;
  logic [POS_W-1:0]   px_r, py_r, pz_r;
  logic [POS_W-2:0]   hx_r, hy_r;
  logic signed [27:0] x1_r, y1_r;
  logic signed [55:0] sqx1_r, sqy1_r;
  logic signed [45:0] pxc_r, pys_r, pxs_r, pyc_r;

  // Decide datapath
  logic signed [OPOS_W-1:0] ix_r, iy_r;
  logic [POS_W-1:0]   iz_r;
  logic [3:0]         ikind_r;
  logic [OPOS_W-1:0]  ax_r, ay_r, az_r;
  logic [POS_W-1:0]   rx_r, ry_r, rz_r;
  logic [STEP_W-1:0]  step_r;
  logic [57:0]        sqx_r, sqy_r, sqz_r;
  logic               hit_r;

  // Output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [11:0]        out_idx_r;
  logic [3:0]         out_kind_r;
  logic [OPOS_W-1:0]  out_x_r, out_y_r;
  logic [POS_W-1:0]   out_z_r;
  logic               out_rem_r;
  logic [12:0]        out_kept_r;

  // Store port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;

  // Input field unpack
  logic [3:0]         in_kind;
  logic [POS_W-1:0]   in_x, in_y, in_z;
  logic               in_fire, out_free, last_j;

  // Combinational results
  logic               load_out;
  status_t            res_status;
  logic [11:0]        res_idx;
  logic [3:0]         res_kind;
  logic [OPOS_W-1:0]  res_x, res_y;
  logic [POS_W-1:0]   res_z;
  logic               res_rem;
  logic [12:0]        res_kept;
  logic [OPOS_W-1:0]  rot_x, rot_y;
  logic [OPOS_W-1:0]  dx, dy, dz;
  logic               pair_hit;

  assign in_kind  = in_tdata[3:0];
  assign in_x     = in_tdata[30:4];
  assign in_y     = in_tdata[57:31];
  assign in_z     = in_tdata[84:58];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign last_j   = ((j_r + 1'b1) == loaded_r);

  // One restoring remainder step
  function automatic logic [POS_W-1:0] rem_step(logic [POS_W-1:0] rem, logic abit,
                                                logic [POS_W-1:0] len);
    logic [POS_W:0] sh;
    sh = {rem, abit};
    if (sh >= {1'b0, len}) begin
      sh = sh - {1'b0, len};
    end
    return sh[POS_W-1:0];
  endfunction

  // Minimum-image magnitude from |r| and |r| mod len
  function automatic logic [OPOS_W-1:0] fold(logic [OPOS_W-1:0] a, logic [POS_W-1:0] rem,
                                             logic [POS_W-1:0] len);
    logic [OPOS_W-1:0] res;
    if (len == '0) begin
      res = a;
    end else if ({rem, 1'b0} >= {1'b0, len}) begin
      res = OPOS_W'(len - rem);
    end else begin
      res = OPOS_W'(rem);
    end
    return res;
  endfunction

  function automatic logic [OPOS_W-1:0] abs_diff(logic signed [OPOS_W:0] d);
    logic signed [OPOS_W:0] m;
    m = (d < 0) ? -d : d;
    return m[OPOS_W-1:0];
  endfunction

  function automatic logic [OPOS_W-1:0] sat_pos(logic signed [47:0] v);
    logic signed [47:0] s;
    if (v < OUT_LO) begin
      s = OUT_LO;
    end else if (v > OUT_HI) begin
      s = OUT_HI;
    end else begin
      s = v;
    end
    return s[OPOS_W-1:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r  <= '0;
      box_y_r  <= '0;
      box_z_r  <= '0;
      grain_r  <= '0;
      cos_r    <= 18'sd65536;
      sin_r    <= '0;
      cutoff_r <= 32'hFFFF_FFFF;
      tlim_r   <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_X:  box_x_r  <= cfg_wdata[POS_W-1:0];
        CFG_BOX_Y:  box_y_r  <= cfg_wdata[POS_W-1:0];
        CFG_BOX_Z:  box_z_r  <= cfg_wdata[POS_W-1:0];
        CFG_GRAIN:  grain_r  <= cfg_wdata[51:0];
        CFG_COS:    cos_r    <= cfg_wdata[17:0];
        CFG_SIN:    sin_r    <= cfg_wdata[17:0];
        CFG_CUTOFF: cutoff_r <= cfg_wdata[31:0];
        CFG_TLIM:   tlim_r   <= cfg_wdata[3:0];
        default:    ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == MODE_LOAD) begin
            if (in_kind > tlim_r || loaded_r >= CNT_W'(MAX_ATOMS)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LD_MUL;
            end
          end else if (dptr_r >= loaded_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DC_GETI;
          end
        end
      end
      S_LD_MUL:  state_nxt = S_LD_FIN;
      S_DC_GETI: state_nxt = S_DC_RDJ;
      S_DC_RDJ:  state_nxt = S_DC_GETJ;
      S_DC_GETJ: begin
        if (ram_rdata[RAM_W-1]) begin
          state_nxt = last_j ? S_DC_FIN : S_DC_RDJ;
        end else begin
          state_nxt = S_DC_DIV;
        end
      end
      S_DC_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DC_SQ;
        end
      end
      S_DC_SQ: state_nxt = S_DC_CMP;
      S_DC_CMP: begin
        if (pair_hit || last_j) begin
          state_nxt = S_DC_FIN;
        end else begin
          state_nxt = S_DC_RDJ;
        end
      end
      S_LD_FIN, S_DC_FIN, S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Rotation result of a load
  always_comb begin
    logic signed [47:0] sx, sy, tx, ty;
    logic [56:0] r2;
    r2 = 57'(sqx1_r) + 57'(sqy1_r);
    sx = 48'(pxc_r) - 48'(pys_r);
    sy = 48'(pxs_r) + 48'(pyc_r);
    tx = (sx + RND) >>> FRAC_BITS;
    ty = (sy + RND) >>> FRAC_BITS;
    if (r2 <= 57'(grain_r)) begin
      rot_x = sat_pos(tx + 48'(signed'({1'b0, hx_r})));
      rot_y = sat_pos(ty + 48'(signed'({1'b0, hy_r})));
    end else begin
      rot_x = OPOS_W'(px_r);
      rot_y = OPOS_W'(py_r);
    end
  end

  // Pair distance from the registered squares
  always_comb begin
    logic [59:0] d2;
    d2 = 60'(sqx_r) + 60'(sqy_r) + 60'(sqz_r);
    pair_hit = (d2 != '0) && (d2 < 60'(cutoff_r));
  end

  assign dx = fold(ax_r, rx_r, box_x_r);
  assign dy = fold(ay_r, ry_r, box_y_r);
  assign dz = fold(az_r, rz_r, box_z_r);

  // Outputs: store port and result payload
  always_comb begin
    ram_we     = 1'b0;
    ram_addr   = dptr_r[ADDR_W-1:0];
    ram_wdata  = {1'b0, ikind_r, iz_r, iy_r, ix_r};
    load_out   = 1'b0;
    res_status = ST_OK;
    res_idx    = 12'(dptr_r);
    res_kind   = '0;
    res_x      = '0;
    res_y      = '0;
    res_z      = '0;
    res_rem    = 1'b0;
    res_kept   = 13'(kept_r);
    unique case (state_r)
      S_DC_RDJ: ram_addr = j_r[ADDR_W-1:0];
      S_LD_FIN: begin
        ram_addr  = loaded_r[ADDR_W-1:0];
        ram_wdata = {1'b0, kind_r, pz_r, rot_y, rot_x};
        ram_we    = out_free;
        load_out  = out_free;
        res_idx   = 12'(loaded_r);
        res_kind  = kind_r;
        res_x     = rot_x;
        res_y     = rot_y;
        res_z     = pz_r;
      end
      S_DC_FIN: begin
        ram_wdata = {hit_r, ikind_r, iz_r, iy_r, ix_r};
        ram_we    = out_free;
        load_out  = out_free;
        res_kind  = ikind_r;
        res_x     = ix_r;
        res_y     = iy_r;
        res_z     = iz_r;
        res_rem   = hit_r;
        res_kept  = 13'(hit_r ? kept_r : kept_r + 1'b1);
      end
      S_EMIT: begin
        load_out   = out_free;
        res_status = status_r;
        if (mode_r == MODE_LOAD) begin
          res_idx  = 12'(loaded_r);
          res_kind = kind_r;
        end
      end
      default: ;
    endcase
  end

  gcpr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_ATOMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      dptr_r   <= '0;
      kept_r   <= '0;
    end else begin
      if (state_r == S_LD_FIN && out_free) begin
        loaded_r <= loaded_r + 1'b1;
      end
      if (state_r == S_DC_FIN && out_free) begin
        dptr_r <= dptr_r + 1'b1;
        if (!hit_r) begin
          kept_r <= kept_r + 1'b1;
        end
      end
    end
  end

  // Load datapath: recenter on accept, then products
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_tuser;
      kind_r   <= in_kind;
      px_r     <= in_x;
      py_r     <= in_y;
      pz_r     <= in_z;
      hx_r     <= box_x_r[POS_W-1:1];
      hy_r     <= box_y_r[POS_W-1:1];
      x1_r     <= signed'({1'b0, in_x}) - signed'({2'b0, box_x_r[POS_W-1:1]});
      y1_r     <= signed'({1'b0, in_y}) - signed'({2'b0, box_y_r[POS_W-1:1]});
      if (in_tuser == MODE_DECIDE) begin
        status_r <= ST_EMPTY;
      end else if (in_kind > tlim_r) begin
        status_r <= ST_TYPE;
      end else begin
        status_r <= ST_FULL;
      end
    end
    if (state_r == S_LD_MUL) begin
      sqx1_r <= x1_r * x1_r;
      sqy1_r <= y1_r * y1_r;
      pxc_r  <= x1_r * cos_r;
      pys_r  <= y1_r * sin_r;
      pxs_r  <= x1_r * sin_r;
      pyc_r  <= y1_r * cos_r;
    end
  end

  // Decide datapath: scan sequencer, remainder unit and squares
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_DC_GETI: begin
        ix_r    <= ram_rdata[OPOS_W-1:0];
        iy_r    <= ram_rdata[2*OPOS_W-1:OPOS_W];
        iz_r    <= ram_rdata[2*OPOS_W+POS_W-1:2*OPOS_W];
        ikind_r <= ram_rdata[RAM_W-2:RAM_W-5];
        j_r     <= '0;
        hit_r   <= 1'b0;
      end
      S_DC_GETJ: begin
        ax_r   <= abs_diff(OPOS_W'(ix_r) - (OPOS_W+1)'(signed'(ram_rdata[OPOS_W-1:0])));
        ay_r   <= abs_diff(OPOS_W'(iy_r) -
                           (OPOS_W+1)'(signed'(ram_rdata[2*OPOS_W-1:OPOS_W])));
        az_r   <= abs_diff(signed'((OPOS_W+1)'(iz_r)) -
                           signed'((OPOS_W+1)'(ram_rdata[2*OPOS_W+POS_W-1:2*OPOS_W])));
        rx_r   <= '0;
        ry_r   <= '0;
        rz_r   <= '0;
        step_r <= '0;
        if (ram_rdata[RAM_W-1]) begin
          j_r <= j_r + 1'b1;
        end
      end
      S_DC_DIV: begin
        // rotate the magnitude so it is whole again after the last step
        rx_r   <= rem_step(rx_r, ax_r[OPOS_W-1], box_x_r);
        ry_r   <= rem_step(ry_r, ay_r[OPOS_W-1], box_y_r);
        rz_r   <= rem_step(rz_r, az_r[OPOS_W-1], box_z_r);
        ax_r   <= {ax_r[OPOS_W-2:0], ax_r[OPOS_W-1]};
        ay_r   <= {ay_r[OPOS_W-2:0], ay_r[OPOS_W-1]};
        az_r   <= {az_r[OPOS_W-2:0], az_r[OPOS_W-1]};
        step_r <= step_r + 1'b1;
      end
      S_DC_SQ: begin
        sqx_r <= dx * dx;
        sqy_r <= dy * dy;
        sqz_r <= dz * dz;
      end
      S_DC_CMP: begin
        hit_r <= pair_hit;
        if (!pair_hit) begin
          j_r <= j_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_kind_r   <= res_kind;
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_z_r      <= res_z;
      out_rem_r    <= res_rem;
      out_kept_r   <= res_kept;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_kept_r, out_rem_r, out_z_r, out_y_r, out_x_r,
                       out_kind_r, out_idx_r};

`ifndef SYNTHESIS
  // The store is written only when a result is committed
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_LD_FIN) || (state_r == S_DC_FIN)) && out_free)
    else $error("store written outside a commit");

  // Decides never run ahead of loads
  assert property (@(posedge clk) disable iff (!rst_n) dptr_r <= loaded_r)
    else $error("decide pointer beyond loaded count");

  // Kept atoms are a subset of decided atoms
  assert property (@(posedge clk) disable iff (!rst_n) kept_r <= dptr_r)
    else $error("kept count beyond decided count");

  // The scan index stays below the loaded count
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DC_RDJ) || (state_r == S_DC_DIV)) |-> (j_r < loaded_r))
    else $error("scan index out of range");
`endif

endmodule
